// ===== rtl/aesrou_pkg.sv =====
// Shared types, constants and GF(2^8) helpers for the AES round operation unit.
// No dependencies; imported by aesrou_transform and aes_round_operation_unit_core.
package aesrou_pkg;

	localparam int unsigned BlockBytes = 16;
	localparam int unsigned BlockBits  = 8 * BlockBytes;

	localparam logic [7:0] GfReduce = 8'h1B;
	localparam logic [7:0] GfTopBit = 8'h80;

	typedef enum logic [2:0] {
		MODE_ADDKEY    = 3'd0,
		MODE_SUBBYTES  = 3'd1,
		MODE_INVSUB    = 3'd2,
		MODE_SHIFTROWS = 3'd3,
		MODE_INVSHIFT  = 3'd4,
		MODE_MIXCOLS   = 3'd5,
		MODE_INVMIX    = 3'd6,
		MODE_PASS      = 3'd7
	} mode_t;

	typedef logic [BlockBits-1:0] block_t;

	// Forward S-box, entry 0 first.
	localparam logic [7:0] SBOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	// Inverse S-box, entry 0 first.
	localparam logic [7:0] RSBOX [256] = '{
		8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
		8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
		8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
		8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
		8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
		8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
		8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
		8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
		8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
		8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
		8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
		8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
		8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
		8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
		8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
		8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
		8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
		8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
		8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
		8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
		8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
		8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
		8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
		8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
		8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
		8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
		8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
		8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
		8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
		8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
		8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
		8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
	};

	// Multiply by x, reduce by the field polynomial.
	function automatic logic [7:0] xtime(input logic [7:0] a);
		logic [7:0] shl;
		shl = {a[6:0], 1'b0};
		return ((a & GfTopBit) != 8'h00) ? (shl ^ GfReduce) : shl;
	endfunction

	// One column of MixColumns; byte r of the column at bits 8r+7:8r.
	function automatic logic [31:0] mix_col(input logic [31:0] col);
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [31:0] res;
		for (int r = 0; r < 4; r++) begin
			a[r]  = col[8*r +: 8];
			x2[r] = xtime(col[8*r +: 8]);
		end
		for (int r = 0; r < 4; r++) begin
			res[8*r +: 8] = x2[r] ^ x2[(r+1)%4] ^ a[(r+1)%4] ^ a[(r+2)%4] ^ a[(r+3)%4];
		end
		return res;
	endfunction

	// One column of InvMixColumns: coefficients 14, 11, 13, 9 rotating by row.
	function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [7:0] m9 [4];
		logic [7:0] m11 [4];
		logic [7:0] m13 [4];
		logic [7:0] m14 [4];
		logic [31:0] res;
		for (int r = 0; r < 4; r++) begin
			a[r]   = col[8*r +: 8];
			x2[r]  = xtime(a[r]);
			x4[r]  = xtime(x2[r]);
			x8[r]  = xtime(x4[r]);
			m9[r]  = x8[r] ^ a[r];
			m11[r] = x8[r] ^ x2[r] ^ a[r];
			m13[r] = x8[r] ^ x4[r] ^ a[r];
			m14[r] = x8[r] ^ x4[r] ^ x2[r];
		end
		for (int r = 0; r < 4; r++) begin
			res[8*r +: 8] = m14[r] ^ m11[(r+1)%4] ^ m13[(r+2)%4] ^ m9[(r+3)%4];
		end
		return res;
	endfunction

endpackage

// ===== rtl/aesrou_transform.sv =====
// Combinational round transformation: one of the AES round steps, or pass-through, on a 128-bit state.
// Depends on aesrou_pkg (mode codes, S-box tables, column mix functions).
module aesrou_transform import aesrou_pkg::*; (
	input  mode_t  mode,
	input  block_t state,
	input  block_t round_key,
	output block_t result
);

	block_t addkey_v;
	block_t sub_v;
	block_t invsub_v;
	block_t shift_v;
	block_t invshift_v;
	block_t mix_v;
	block_t invmix_v;

	always_comb begin
		addkey_v = state ^ round_key;
		for (int i = 0; i < BlockBytes; i++) begin
			sub_v[8*i +: 8]    = SBOX[state[8*i +: 8]];
			invsub_v[8*i +: 8] = RSBOX[state[8*i +: 8]];
		end
		// Row r of column c takes row r of column c+r (forward) or c-r (inverse).
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				shift_v[8*(r + 4*c) +: 8]    = state[8*(r + 4*((c + r) % 4)) +: 8];
				invshift_v[8*(r + 4*c) +: 8] = state[8*(r + 4*((c - r + 4) % 4)) +: 8];
			end
			mix_v[32*c +: 32]    = mix_col(state[32*c +: 32]);
			invmix_v[32*c +: 32] = inv_mix_col(state[32*c +: 32]);
		end
	end

	always_comb begin
		case (mode)
			MODE_ADDKEY:    result = addkey_v;
			MODE_SUBBYTES:  result = sub_v;
			MODE_INVSUB:    result = invsub_v;
			MODE_SHIFTROWS: result = shift_v;
			MODE_INVSHIFT:  result = invshift_v;
			MODE_MIXCOLS:   result = mix_v;
			MODE_INVMIX:    result = invmix_v;
			default:        result = state;
		endcase
	end

endmodule

// ===== rtl/aes_round_operation_unit_core.sv =====
// AES round operation unit: input register, one combinational round step, result register.
// Each block passes through the input register and then the result register; throughput
// 1 block per cycle while out_ready holds.
// The two register stages advance together under one valid/ready chain, so a stalled
// output still lets one more transaction enter the input register.
// Reset (arst_n low, asynchronous) clears both stage valids; payload registers are not reset.
module aes_round_operation_unit_core import aesrou_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [63:0] block_lo,
	input  logic [63:0] block_hi,
	input  logic [63:0] round_key_lo,
	input  logic [63:0] round_key_hi,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result_lo,
	output logic [63:0] result_hi
);

	// Input register stage: holds one captured transaction.
	logic   valid_s1;
	mode_t  mode_s1;
	block_t state_s1;
	block_t key_s1;

	// Result register: holds the transformed block until the consumer takes it.
	logic   out_valid_q;
	block_t result_q;

	block_t xform_result;
	logic   load_out;
	logic   load_s1;

	// The result register can load when empty or when its content leaves this cycle.
	assign load_out = !out_valid_q || out_ready;

	// The input stage frees up when empty or when its item moves to the result register.
	assign in_ready = !valid_s1 || load_out;
	assign load_s1  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture the payload only on an accepted transaction; hold otherwise.
	always_ff @(posedge clk) begin
		if (load_s1) begin
			mode_s1  <= mode_t'(mode);
			state_s1 <= {block_hi, block_lo};
			key_s1   <= {round_key_hi, round_key_lo};
		end
	end

	aesrou_transform u_xform (
		.mode      (mode_s1),
		.state     (state_s1),
		.round_key (key_s1),
		.result    (xform_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= valid_s1;
		end
	end

	// Advance the result only when a valid item moves down; drop nothing.
	always_ff @(posedge clk) begin
		if (load_out && valid_s1) begin
			result_q <= xform_result;
		end
	end

	assign out_valid = out_valid_q;
	assign result_lo = result_q[63:0];
	assign result_hi = result_q[127:64];

	// An empty result register never blocks the input side.
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled while result register empty");

	// An accepted transaction is held in the input stage on the next cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted transaction lost at input stage");

	// A valid input stage moving down always produces a result.
	a_s1_moves_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && load_out) |=> out_valid_q)
		else $error("item lost between input stage and result register");

	// A stalled result stays put, so the input stage must hold its item too.
	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ready) |=> valid_s1)
		else $error("input stage dropped an item under output stall");

endmodule
